// ----- hw/rtl/bwe_pkg.sv -----
`default_nettype none

package bwe_pkg;

   // one accepted input beat
   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   // one result beat: a byteword letter pair
   typedef struct packed {
      logic [6:0] first_letter;
      logic [6:0] second_letter;
      logic       end_of_text;
   } rsp_type;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [7:0]  CASE_OFFSET = 8'h20;

   // CRC trailer: four bytes, MSB first
   localparam int unsigned TRAILER_PAIRS = 4;
   localparam int unsigned TRAILER_CNT_W = 3;

   // minimal bytewords, two lower-case letters per byte value;
   // char k sits at bits [8*(511-k) +: 8]
   localparam logic [4095:0] WORD_LETTERS = {
      "aeadaoaxaaahamatayasbkbdbnbtbabs",
      "bebybgbwbbbzcmchcscfcycwcecackct",
      "cxclcpcndkdadsdidedtdrdndwdpdmdl",
      "dyeheyeoeeecenemetesftfrfnfsfmfh",
      "fzfpfwfxfyfefgflfdgagegrgsgtglgw",
      "gdgygmgughgohfhghdhkhthphhhlhyhe",
      "hnhsidiaieihiyioisinimjejzjnjtjl",
      "jojsjpjkjykpkoktkskkknkgkekikblb",
      "lalylflslrlplnltloldlelulklgmnmy",
      "mhmemomumwmdmtmsmknlnyndnsntnnne",
      "nboyoeotoxonolospdptpkpypspmplpe",
      "pfpaprqdqzrerprlrorhrdrkrfryrnrs",
      "rtsesasrssskswstspsosgsbsfsntotk",
      "titttdtetytltbtstptatnuyuoutueur",
      "vtvyvovlvevwvavdvswlwdwmwpwewyws",
      "wtwnwzwfwkykynylyaytzszoztzczezm"
   };

   // upper-case letter of a byteword; second selects the last letter
   function automatic logic [6:0] word_letter(input logic [7:0] b, input logic second);
      logic [8:0] pos;
      logic [7:0] ch;
      pos = {b, second};
      // 8*(511-pos) is ~pos shifted by three
      ch  = WORD_LETTERS[{~pos, 3'b000} +: 8];
      return 7'(ch - CASE_OFFSET);
   endfunction

   // full result beat for one byte
   function automatic rsp_type word_pair(input logic [7:0] b, input logic last);
      rsp_type r;
      r.first_letter  = word_letter(b, 1'b0);
      r.second_letter = word_letter(b, 1'b1);
      r.end_of_text   = last;
      return r;
   endfunction

   // reflected CRC-32, one byte, bit at a time
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bytewords_minimal_encoder_crc32_core.sv -----
`default_nettype none
// A byte's letter pair is registered, valid in the cycle after the byte is accepted.
// Throughput: one byte per cycle while rsp_ready does not stall the output; a final
// byte adds four CRC pairs, one per cycle when not stalled, during which req_ready
// stays low. The single output register and the trailer counter set these figures.
// Reset (synchronous, active high) empties the output and sets the CRC to all ones.

module bytewords_minimal_encoder_crc32_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bwe_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output bwe_pkg::rsp_type      rsp_data
);
   import bwe_pkg::*;

   logic [31:0] crc_result;
   logic        accept;

   assign accept = req_valid && req_ready;

   // running CRC-32 over the message
   bwe_crc_unit u_crc (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .crc_result (crc_result)
   );

   // letter lookup, trailer sequencing and output register
   bwe_rsp_stage u_rsp (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .crc_result (crc_result),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/bwe_crc_unit.sv -----
`default_nettype none

module bwe_crc_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire bwe_pkg::req_type req_data,
   output logic [31:0]           crc_result
);
   import bwe_pkg::*;

   logic [31:0] crc_ff;
   logic [31:0] crc_in;
   logic [31:0] crc_next;

   // running CRC after this beat's byte
   assign crc_next   = crc_byte(crc_ff, req_data.data_byte);
   // final complement, valid for the beat being accepted
   assign crc_result = ~crc_next;

   // restart after a final byte
   always_comb begin
      crc_in = crc_ff;
      if (accept) begin
         crc_in = req_data.final_byte ? CRC_INIT : crc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_INIT;
      end else begin
         crc_ff <= crc_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/bwe_rsp_stage.sv -----
`default_nettype none

module bwe_rsp_stage (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bwe_pkg::req_type req_data,
   input  wire logic [31:0]      crc_result,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output bwe_pkg::rsp_type      rsp_data
);
   import bwe_pkg::*;

   localparam logic [TRAILER_CNT_W-1:0] CNT_FULL = TRAILER_CNT_W'(TRAILER_PAIRS);
   localparam logic [TRAILER_CNT_W-1:0] CNT_ONE  = TRAILER_CNT_W'(1);

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic [TRAILER_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]              trl_ff, trl_in;
   logic                     slot_free;
   logic                     accept;
   logic                     trl_busy;

   // output slot can take a beat this cycle
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign trl_busy  = (cnt_ff != '0);
   assign req_ready = slot_free && !trl_busy;
   assign accept    = req_valid && req_ready;

   // load message pair, or next CRC pair while the trailer runs
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cnt_in       = cnt_ff;
      trl_in       = trl_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = word_pair(req_data.data_byte, 1'b0);
         if (req_data.final_byte) begin
            cnt_in = CNT_FULL;
            trl_in = crc_result;
         end
      end else if (trl_busy && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = word_pair(trl_ff[31:24], cnt_ff == CNT_ONE);
         cnt_in       = cnt_ff - CNT_ONE;
         trl_in       = {trl_ff[23:0], 8'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      rsp_data_ff <= rsp_data_in;
      trl_ff      <= trl_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // no new byte while the trailer is pending
   a_no_accept_in_trailer: assert property (@(posedge clock) disable iff (reset)
      trl_busy |-> !req_ready) else $error("byte taken during CRC trailer");

   // a final byte arms the full trailer
   a_final_arms: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.final_byte |=> cnt_ff == CNT_FULL)
      else $error("trailer not armed after final byte");

   // end of text only once the trailer is spent
   a_eot_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.end_of_text |-> cnt_ff == '0)
      else $error("end of text with trailer pairs left");

   // counter never exceeds the trailer length
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL) else $error("trailer count out of range");

endmodule

`default_nettype wire
